// ===== rtl/p2ma_pkg.sv =====
// shared types and constants for the 2-d polynomial moment accumulator
`default_nettype none
package p2ma_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEL_MOMENT = 2'd0,
    SEL_XTGT   = 2'd1,
    SEL_YTGT   = 2'd2,
    SEL_NONE   = 2'd3
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TERM,
    ST_RMW,
    ST_NEXT,
    ST_RDWAIT,
    ST_RDOUT
  } state_e;

  localparam int unsigned CountW = 24;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [31:0] RegFitOrder = 32'd0;
  localparam logic signed [16:0] OneQ15 = 17'sd32768;

  // floor(a*b / 2^15) for power values in [-32768, 32768]
  function automatic logic signed [16:0] mul_trunc(input logic signed [16:0] a,
                                                   input logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b;
    return p[31:15];
  endfunction

  // 64-bit saturating add, returns sum and overflow flag
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
    end
    return {1'b0, s[63:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/p2ma_ram.sv =====
// single-port-write, one-read synchronous memory for accumulator entries
`default_nettype none
module p2ma_ram #(
  parameter int unsigned Depth = 49,
  parameter int unsigned AddrW = 6,
  parameter int unsigned Width = 64
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/poly2d_moment_accumulator.sv =====
// top level of the 2-d polynomial moment accumulator
//
// channels: slave stream s_axis_* takes command words (add, clear, read), master
// stream m_axis_* returns one word per read; apb port holds fit_order at address 0.
// an add walks every (n,m) pair of the triangle n+m < 2*order+1, pair by pair:
// form the power product and read the table entries, then write back the
// saturated sums (target sums only where n+m <= order). the moment table is a
// 64-bit memory and the x and y target tables share one 128-bit memory, both
// indexed n*(2*MAX_ORDER+1)+m with registered reads; the walk is sequential so
// no two accesses to one entry overlap. an add of order o walks (o+1)*(2o+1)
// pairs (15 at order 2).
// a clear sweeps all (2*MAX_ORDER+1)^2 entries, one per cycle.
// a read word is addressed in ST_RDWAIT and its result registered in ST_RDOUT;
// while the result waits on a stalled receiver the block takes no further word.
// after reset a clearing pass over all entries runs before s_axis_tready rises;
// the count and saturation flag reset at once, fit_order resets to 1.
`default_nettype none
module poly2d_moment_accumulator
  import p2ma_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // op[1:0], point_x[17:2], point_y[33:18], target_x[49:34], target_y[65:50],
  // table_select[67:66], x_power[70:68], y_power[73:71], zero fill
  input  wire logic [79:0] s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // read_value[63:0], points_added[87:64], saturated[88], zero fill
  output      logic [95:0] m_axis_tdata_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [1:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output      logic [31:0] prdata_o,
  output      logic        pready_o
);
  localparam int unsigned Nt = 2 * MAX_ORDER + 1;
  localparam int unsigned Depth = Nt * Nt;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PowW = $clog2(Nt + 1);
  localparam int unsigned OrdW = $clog2(MAX_ORDER + 1);

  // configuration
  logic [1:0] fit_order_q;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == RegFitOrder[1:0]) ? {30'd0, fit_order_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_order_q <= 2'd1;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == RegFitOrder[1:0]) begin
      fit_order_q <= pwdata_i[1:0];
    end
  end

  // effective order clamped to 1..MAX_ORDER
  logic [OrdW:0] order;
  always_comb begin
    if (fit_order_q == 2'd0) order = (OrdW+1)'(1);
    else if (32'(fit_order_q) > MAX_ORDER) order = (OrdW+1)'(MAX_ORDER);
    else order = (OrdW+1)'(fit_order_q);
  end
  logic [PowW:0] nt_eff;
  assign nt_eff = (PowW+1)'({order, 1'b1});

  // input fields
  logic [1:0] in_op;
  logic signed [15:0] in_px, in_py, in_tx, in_ty;
  assign in_op = s_axis_tdata_i[1:0];
  assign in_px = s_axis_tdata_i[17:2];
  assign in_py = s_axis_tdata_i[33:18];
  assign in_tx = s_axis_tdata_i[49:34];
  assign in_ty = s_axis_tdata_i[65:50];

  state_e state_q, state_d;
  logic signed [15:0] px_q, py_q, tx_q, ty_q;
  logic [1:0] sel_q;
  logic [2:0] rn_q, rm_q;
  logic [PowW-1:0] n_q, n_d, m_q, m_d;
  logic signed [16:0] xp_q, xp_d, yp_q, yp_d, term_q, term_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic sat_q, sat_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [95:0] out_q, out_d;
  logic ovalid_q, ovalid_d;

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !ovalid_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o = out_q;

  // memories: moment table, and x/y target tables side by side
  logic [AddrW-1:0] raddr, waddr, cur_addr;
  logic we;
  logic [63:0] wd_m, wd_x, wd_y, rd_m, rd_x, rd_y;
  logic [127:0] wd_tgt, rd_tgt;
  assign cur_addr = AddrW'(32'(n_q) * Nt + 32'(m_q));
  assign wd_tgt = {wd_y, wd_x};
  assign rd_x = rd_tgt[63:0];
  assign rd_y = rd_tgt[127:64];

  p2ma_ram #(.Depth(Depth), .AddrW(AddrW), .Width(64)) u_mom (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wd_m), .raddr_i(raddr), .rdata_o(rd_m));
  p2ma_ram #(.Depth(Depth), .AddrW(AddrW), .Width(128)) u_tgt (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wd_tgt), .raddr_i(raddr),
    .rdata_o(rd_tgt));

  // read-modify-write datapath
  logic signed [63:0] tterm_x, tterm_y;
  logic [64:0] s_m, s_x, s_y;
  logic in_tgt;
  assign tterm_x = 64'(tx_q) * 64'(term_q);
  assign tterm_y = 64'(ty_q) * 64'(term_q);
  assign s_m = sat_add(rd_m, 64'(term_q));
  assign s_x = sat_add(rd_x, tterm_x);
  assign s_y = sat_add(rd_y, tterm_y);
  assign in_tgt = (32'(n_q) + 32'(m_q)) <= 32'(order);

  // read lookup
  logic [3:0] rsum;
  logic signed [63:0] rval;
  assign rsum = 4'(rn_q) + 4'(rm_q);
  always_comb begin
    rval = 64'd0;
    case (sel_q)
      SEL_MOMENT: if (32'(rsum) < 32'(nt_eff)) rval = rd_m;
      SEL_XTGT:   if (32'(rsum) <= 32'(order)) rval = rd_x;
      SEL_YTGT:   if (32'(rsum) <= 32'(order)) rval = rd_y;
      default:    rval = 64'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q; m_d = m_q; xp_d = xp_q; yp_d = yp_q; term_d = term_q;
    cnt_d = cnt_q; sat_d = sat_q; clr_d = clr_q;
    out_d = out_q; ovalid_d = ovalid_q;
    we = 1'b0; waddr = cur_addr; raddr = cur_addr;
    wd_m = 64'd0; wd_x = 64'd0; wd_y = 64'd0;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(in_op))
            OP_ADD: begin
              n_d = '0; m_d = '0; xp_d = OneQ15; yp_d = OneQ15;
              state_d = ST_TERM;
            end
            OP_CLEAR: begin
              clr_d = '0; cnt_d = '0; sat_d = 1'b0;
              state_d = ST_CLEAR;
            end
            OP_READ: state_d = ST_RDWAIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q;
        clr_d = clr_q + AddrW'(1);
        if (32'(clr_q) == Depth - 1) state_d = ST_IDLE;
      end
      ST_TERM: begin
        // term registered, entries read
        term_d = mul_trunc(xp_q, yp_q);
        state_d = ST_RMW;
      end
      ST_RMW: begin
        we = 1'b1;
        wd_m = s_m[63:0];
        wd_x = in_tgt ? s_x[63:0] : rd_x;
        wd_y = in_tgt ? s_y[63:0] : rd_y;
        if (s_m[64] || (in_tgt && (s_x[64] || s_y[64]))) sat_d = 1'b1;
        yp_d = mul_trunc(yp_q, {py_q[15], py_q});
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (32'(n_q) + 32'(m_q) + 1 < 32'(nt_eff)) begin
          m_d = m_q + PowW'(1);
          state_d = ST_TERM;
        end else if (32'(n_q) + 1 < 32'(nt_eff)) begin
          n_d = n_q + PowW'(1); m_d = '0;
          xp_d = mul_trunc(xp_q, {px_q[15], px_q});
          yp_d = OneQ15;
          state_d = ST_TERM;
        end else begin
          if (cnt_q != CountMax) cnt_d = cnt_q + CountW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        raddr = AddrW'(32'(rn_q) * Nt + 32'(rm_q));
        state_d = ST_RDOUT;
      end
      ST_RDOUT: begin
        out_d = {7'd0, sat_q, cnt_q, rval};
        ovalid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      sat_q <= sat_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; m_q <= m_d; xp_q <= xp_d; yp_q <= yp_d; term_q <= term_d;
    out_q <= out_d;
    if (accept) begin
      px_q <= in_px; py_q <= in_py; tx_q <= in_tx; ty_q <= in_ty;
      sel_q <= s_axis_tdata_i[67:66];
      rn_q <= s_axis_tdata_i[70:68];
      rm_q <= s_axis_tdata_i[73:71];
    end
  end

  // rn_q/rm_q beyond the table width alias; mask reads outside the triangle above
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o) else $error("accept while busy");
  a_out_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDOUT) |=> m_axis_tvalid_o) else $error("read result missing");
  a_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM) |=> (state_q == ST_RMW)) else $error("walk out of order");
endmodule
`default_nettype wire
